@@ design/psl_pkg.sv @@
// shared types and constants for the pot smoother with lock
// no dependencies; imported by every module of the block
package psl_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam int VAL_W = 20;
	localparam int TIME_W = 32;
	localparam int RAW_W = 12;
	localparam int ALPHA_W = 16;
	localparam int TMO_W = 16;
	localparam int CHAN_W = 5;

	// multiply-accumulate widths: 17-bit weight times 20-bit value; the accumulator is as wide as the product
	localparam int MAC_A_W = ALPHA_W + 1;
	localparam int MAC_ACC_W = MAC_A_W + VAL_W;

	localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W + 1)'(NUM_CHANNELS);
	localparam logic [VAL_W-1:0] MID_SCALE = 20'd524160;
	localparam logic [MAC_ACC_W-1:0] ROUND_HALF = MAC_ACC_W'(32768);
	localparam logic [MAC_A_W-1:0] ALPHA_ONE = MAC_A_W'(65536);

	localparam logic [VAL_W-1:0] LOCKED_THR_RST = 20'd52416;
	localparam logic [VAL_W-1:0] ACTIVE_THR_RST = 20'd10483;
	localparam logic [TMO_W-1:0] LOCK_TMO_RST = 16'd1000;
	localparam logic [ALPHA_W-1:0] EMA_ALPHA_RST = 16'd10486;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 48;

	typedef enum logic [1:0] {
		ACT_SAMPLE   = 2'd0,
		ACT_PRELOAD  = 2'd1,
		ACT_LOCK_ALL = 2'd2,
		ACT_QUERY    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_LOCKED_THR = 2'd0,
		REG_ACTIVE_THR = 2'd1,
		REG_LOCK_TMO   = 2'd2,
		REG_EMA_ALPHA  = 2'd3
	} cfg_reg_t;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctl_t;

endpackage

@@ design/psl_mac.sv @@
// shared multiply-accumulate unit of the pot smoother
// depends on psl_pkg for widths, rounding constant and the control struct
module psl_mac (
	input  logic                             clk,
	input  psl_pkg::mac_ctl_t                ctl,
	input  logic [psl_pkg::MAC_A_W-1:0]      op_a,
	input  logic [psl_pkg::VAL_W-1:0]        op_b,
	output logic [psl_pkg::MAC_ACC_W-1:0]    acc
);
	import psl_pkg::*;

	logic [MAC_ACC_W-1:0] acc_q;
	logic [MAC_ACC_W-1:0] prod;
	logic [MAC_ACC_W-1:0] base;

	assign prod = MAC_ACC_W'(op_a) * MAC_ACC_W'(op_b);
	// clear seeds the accumulator with the rounding half
	assign base = ctl.clr ? ROUND_HALF : acc_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + prod;
		end
	end

	assign acc = acc_q;

endmodule

@@ design/pot_smoother_with_lock.sv @@
// top level of the pot smoother with lock: sequencer, channel stores, config
// depends on psl_pkg and psl_mac
// a sample passes through the read, multiply (MUL1, MUL2), compare and done states;
// preload, lock-all, query and out-of-range items go from read straight to compare
// the two ema products share one multiplier, one product per cycle, which sets the sample time
// one item at a time: s_axis_tready is high only while the sequencer is idle
// a finished result waits in the output register while the next item is taken
// reset: config registers to defaults, move timers to zero, lock flags cleared;
// smoothed and baseline entries are undefined until a channel is preloaded, no clearing pass
module pot_smoother_with_lock (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [psl_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // channel, raw_sample, now_ms, zero pad
	input  logic [1:0]                     s_axis_tuser,  // action
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [psl_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // changed, sent_value, smoothed_value,
	                                                      // channel_ok, zero pad
	// config write port
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [psl_pkg::VAL_W-1:0]      cfg_data
);
	import psl_pkg::*;

	// one-hot sequencer
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_MUL1 = 6'b000100,
		S_MUL2 = 6'b001000,
		S_CMP  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// config registers
	logic [VAL_W-1:0]   locked_thr_q;
	logic [VAL_W-1:0]   active_thr_q;
	logic [TMO_W-1:0]   lock_tmo_q;
	logic [ALPHA_W-1:0] ema_alpha_q;

	// latched input item
	action_t            action_q;
	logic [CHAN_W-1:0]  ch_q;
	logic [RAW_W-1:0]   raw_q;
	logic [TIME_W-1:0]  now_q;

	// channel stores; last-move entries read as zero unless their valid bit is set
	logic [VAL_W-1:0]  smooth_mem [NUM_CHANNELS];
	logic [VAL_W-1:0]  base_mem   [NUM_CHANNELS];
	logic [TIME_W-1:0] move_mem   [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] move_valid_q;
	// set by lock-all: baseline of the channel equals its smoothed value
	logic [NUM_CHANNELS-1:0] sync_q;

	logic [VAL_W-1:0]  rd_smooth_q;
	logic [VAL_W-1:0]  rd_base_q;
	logic [TIME_W-1:0] rd_move_q;

	// result and output registers
	logic [M_TDATA_W-1:0] res_q;
	logic [M_TDATA_W-1:0] m_data_q;
	logic                 m_valid_q;

	// datapath
	logic [CH_W-1:0]      addr;
	logic [VAL_W-1:0]     sample_fx;
	logic                 ok_w;
	logic                 is_sample;
	logic                 is_preload;
	logic                 is_lock_all;
	mac_ctl_t             mac_ctl;
	logic [MAC_A_W-1:0]   mac_a;
	logic [VAL_W-1:0]     mac_b;
	logic [MAC_ACC_W-1:0] mac_acc;
	logic [VAL_W-1:0]     s_new;
	logic [VAL_W-1:0]     base_w;
	logic [TIME_W-1:0]    move_w;
	logic [TIME_W-1:0]    elapsed;
	logic [VAL_W-1:0]     thr_w;
	logic [VAL_W-1:0]     diff_w;
	logic                 chg_w;
	logic                 changed_w;
	logic [VAL_W-1:0]     sent_w;
	logic [VAL_W-1:0]     smooth_out_w;
	logic                 in_xfer;
	logic                 out_free;

	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	// output register can take a new result
	assign out_free = !m_valid_q || m_axis_tready;

	assign addr = ch_q[CH_W-1:0];
	assign sample_fx = {raw_q, 8'h00};
	assign ok_w = {1'b0, ch_q} < CH_LIMIT;
	assign is_sample = ok_w && (action_q == ACT_SAMPLE);
	assign is_preload = ok_w && (action_q == ACT_PRELOAD);
	assign is_lock_all = (action_q == ACT_LOCK_ALL);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) state_d = S_READ;
			end
			S_READ: begin
				// only an in-range sample needs the multiplier
				state_d = is_sample ? S_MUL1 : S_CMP;
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_CMP;
			S_CMP:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_thr_q <= LOCKED_THR_RST;
			active_thr_q <= ACTIVE_THR_RST;
			lock_tmo_q <= LOCK_TMO_RST;
			ema_alpha_q <= EMA_ALPHA_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOCKED_THR: locked_thr_q <= cfg_data;
				REG_ACTIVE_THR: active_thr_q <= cfg_data;
				REG_LOCK_TMO:   lock_tmo_q <= cfg_data[TMO_W-1:0];
				REG_EMA_ALPHA:  ema_alpha_q <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_q <= action_t'(s_axis_tuser);
			ch_q <= s_axis_tdata[CHAN_W-1:0];
			raw_q <= s_axis_tdata[CHAN_W +: RAW_W];
			now_q <= s_axis_tdata[CHAN_W + RAW_W +: TIME_W];
		end
	end

	// store reads, registered
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rd_smooth_q <= smooth_mem[addr];
			rd_base_q <= base_mem[addr];
			rd_move_q <= move_mem[addr];
		end
	end

	// shared multiplier: alpha * sample first, then (1 - alpha) * previous average
	always_comb begin
		mac_ctl = '0;
		mac_a = '0;
		mac_b = '0;
		if (state_q == S_MUL1) begin
			mac_ctl.en = 1'b1;
			mac_ctl.clr = 1'b1;
			mac_a = {1'b0, ema_alpha_q};
			mac_b = sample_fx;
		end else if (state_q == S_MUL2) begin
			mac_ctl.en = 1'b1;
			mac_a = ALPHA_ONE - {1'b0, ema_alpha_q};
			mac_b = rd_smooth_q;
		end
	end

	psl_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.op_a(mac_a),
		.op_b(mac_b),
		.acc (mac_acc)
	);

	// deadband decision
	always_comb begin
		s_new = mac_acc[ALPHA_W +: VAL_W];
		// after lock-all the baseline is the smoothed value read from the store
		base_w = sync_q[addr] ? rd_smooth_q : rd_base_q;
		move_w = move_valid_q[addr] ? rd_move_q : '0;
		elapsed = now_q - move_w;
		// recently moved channels use the fine threshold
		thr_w = (elapsed < {16'd0, lock_tmo_q}) ? active_thr_q : locked_thr_q;
		diff_w = (s_new >= base_w) ? (s_new - base_w) : (base_w - s_new);
		chg_w = diff_w > thr_w;
		changed_w = is_sample && chg_w;
		sent_w = changed_w ? s_new : '0;
		if (!ok_w) begin
			smooth_out_w = MID_SCALE;
		end else if (is_sample) begin
			smooth_out_w = s_new;
		end else if (is_preload) begin
			smooth_out_w = sample_fx;
		end else begin
			smooth_out_w = rd_smooth_q;
		end
	end

	// store writes
	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			if (is_preload) begin
				smooth_mem[addr] <= sample_fx;
				base_mem[addr] <= sample_fx;
			end else if (is_sample) begin
				smooth_mem[addr] <= s_new;
				// folds a pending lock-all baseline into the store
				base_mem[addr] <= chg_w ? s_new : base_w;
				if (chg_w) move_mem[addr] <= now_q;
			end
		end
	end

	// lock flags and move-timer valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_valid_q <= '0;
			sync_q <= '0;
		end else if (state_q == S_CMP) begin
			if (is_lock_all) begin
				// clears every move timer and re-baselines every channel at once
				move_valid_q <= '0;
				sync_q <= '1;
			end else if (is_preload) begin
				move_valid_q[addr] <= 1'b0;
				sync_q[addr] <= 1'b0;
			end else if (is_sample) begin
				sync_q[addr] <= 1'b0;
				if (chg_w) move_valid_q[addr] <= 1'b1;
			end
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		if (state_q == S_CMP) begin
			res_q <= {6'd0, ok_w, smooth_out_w, sent_w, changed_w};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			m_data_q <= res_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

endmodule

@@ design/psl_checker.sv @@
// port-level checks for the pot smoother with lock, bound to the top level
// depends on psl_pkg
module psl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [psl_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import psl_pkg::*;

	// one item at a time: a transfer closes the input until the work is done
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after an input transfer");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

	// no report means no reported value
	a_sent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[20:1] == '0))
		else $error("sent value without a change");

	// out-of-range channel answers mid-scale with no change
	a_bad_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[41]) |->
			(!m_axis_tdata[0] && (m_axis_tdata[40:21] == MID_SCALE)))
		else $error("invalid channel result malformed");

endmodule

bind pot_smoother_with_lock psl_checker u_psl_checker (.*);

@@ verif/pot_smoother_with_lock_test.sv @@
// self-checking testbench for the pot smoother with lock: streams sample, preload,
// lock-all and query transfers through several register settings and checks every result
// depends on psl_pkg and the pot_smoother_with_lock rtl
`timescale 1ns / 1ps

module pot_smoother_with_lock_test;
	import psl_pkg::*;

	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int QUIET_LIMIT = 5000;     // cycles with no transfer on either side
	localparam int SETTLE_CYCLES = 12;     // wait after the last result, with margin for the sample path

	// one input transfer, as the bus carries it
	typedef struct {
		action_t     act;
		logic [4:0]  channel;
		logic [11:0] raw;
		logic [31:0] now;
	} pot_item_t;

	// one result transfer; field order follows m_axis_tdata from the top bit down
	typedef struct packed {
		logic             ok;
		logic [VAL_W-1:0] smooth;
		logic [VAL_W-1:0] sent;
		logic             changed;
	} pot_result_t;

	// keeps its own copy of the channel stores and registers, works out the result
	// of every accepted transfer and compares the block's results in order
	class pot_tracker;
		logic [VAL_W-1:0]   smooth_mem [NUM_CHANNELS];
		logic [VAL_W-1:0]   baseline_mem [NUM_CHANNELS];
		logic [TIME_W-1:0]  moved_at [NUM_CHANNELS];
		logic [VAL_W-1:0]   locked_thr;
		logic [VAL_W-1:0]   active_thr;
		logic [TMO_W-1:0]   lock_tmo;
		logic [ALPHA_W-1:0] alpha;
		pot_result_t        awaited [$];
		int                 errors;
		int                 n_items;
		int                 n_moves;
		int                 n_invalid;

		function new();
			locked_thr = LOCKED_THR_RST;
			active_thr = ACTIVE_THR_RST;
			lock_tmo = LOCK_TMO_RST;
			alpha = EMA_ALPHA_RST;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				smooth_mem[i] = '0;
				baseline_mem[i] = '0;
				moved_at[i] = '0;
			end
		endfunction

		function void set_register(cfg_reg_t idx, logic [VAL_W-1:0] val);
			case (idx)
				REG_LOCKED_THR: locked_thr = val;
				REG_ACTIVE_THR: active_thr = val;
				REG_LOCK_TMO:   lock_tmo = val[TMO_W-1:0];
				REG_EMA_ALPHA:  alpha = val[ALPHA_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_transfer(pot_item_t it);
			pot_result_t       r;
			bit                ok;
			logic [CH_W-1:0]   idx;
			logic [VAL_W-1:0]  sample_fx;
			logic [VAL_W-1:0]  fresh;
			logic [VAL_W-1:0]  base;
			logic [VAL_W-1:0]  thr;
			logic [VAL_W-1:0]  delta;
			logic [TIME_W-1:0] since;
			logic [63:0]       acc;
			r = '0;
			ok = it.channel < NUM_CHANNELS;
			idx = it.channel[CH_W-1:0];
			sample_fx = {it.raw, 8'd0};
			case (it.act)
				ACT_LOCK_ALL: begin
					// every channel re-baselines and its move timer is cleared
					for (int i = 0; i < NUM_CHANNELS; i++) begin
						moved_at[i] = '0;
						baseline_mem[i] = smooth_mem[i];
					end
				end
				ACT_PRELOAD: begin
					if (ok) begin
						smooth_mem[idx] = sample_fx;
						baseline_mem[idx] = sample_fx;
						moved_at[idx] = '0;
					end
				end
				ACT_SAMPLE: begin
					if (ok) begin
						acc = 64'(alpha) * 64'(sample_fx)
							+ (64'd65536 - 64'(alpha)) * 64'(smooth_mem[idx]) + 64'd32768;
						fresh = acc[35:16];
						base = baseline_mem[idx];
						smooth_mem[idx] = fresh;
						since = it.now - moved_at[idx];
						thr = (since < TIME_W'(lock_tmo)) ? active_thr : locked_thr;
						delta = (fresh >= base) ? fresh - base : base - fresh;
						if (delta > thr) begin
							baseline_mem[idx] = fresh;
							moved_at[idx] = it.now;
							r.changed = 1'b1;
							r.sent = fresh;
							n_moves++;
						end
					end
				end
				default: ;  // query: nothing changes
			endcase
			r.ok = ok;
			r.smooth = ok ? smooth_mem[idx] : MID_SCALE;
			if (!ok) n_invalid++;
			n_items++;
			awaited.push_back(r);
		endfunction

		function void check_result(pot_result_t got);
			pot_result_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result %h arrived with nothing expected", $time, got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.changed !== want.changed) begin
				$display("%0t: changed expected %0d actual %0d", $time, want.changed, got.changed);
				errors++;
			end
			if (got.sent !== want.sent) begin
				$display("%0t: sent_value expected %0d actual %0d", $time, want.sent, got.sent);
				errors++;
			end
			if (got.smooth !== want.smooth) begin
				$display("%0t: smoothed_value expected %0d actual %0d", $time,
					want.smooth, got.smooth);
				errors++;
			end
			if (got.ok !== want.ok) begin
				$display("%0t: channel_ok expected %0d actual %0d", $time, want.ok, got.ok);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // channel, raw_sample, now_ms, zero pad
	logic [1:0]           s_axis_tuser = '0;   // action
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;        // changed, sent_value, smoothed_value,
	                                           // channel_ok, zero pad
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_index = '0;
	logic [VAL_W-1:0]     cfg_data = '0;

	pot_tracker tracker = new();

	// sender pacing and stimulus state
	int          burst_left = 0;
	logic [31:0] clock_ms = 32'd0;
	int          aim [NUM_CHANNELS];
	int          quiet_cycles = 0;
	int          stall_mode = 0;
	int          stall_left = 0;
	int          tick = 0;

	pot_smoother_with_lock dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic pot_item_t make_item(action_t act, int ch, int raw, logic [31:0] now);
		pot_item_t it;
		it.act = act;
		it.channel = 5'(ch);
		it.raw = 12'(raw);
		it.now = now;
		return it;
	endfunction

	// offer one transfer and hold it until taken; afterwards either go straight on
	// with the burst or drop tvalid for a random gap
	task automatic send_item(input pot_item_t it);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.act;
		s_axis_tdata <= {7'd0, it.now, it.raw, it.channel};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// now and then a long burst with no gaps at all
			burst_left = (
				$urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 20);
			gap = $urandom_range(1, 12);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// drop tvalid and let the block drain before anything else happens
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (tracker.awaited.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// receiver: switches between always ready, coin flip, mostly stalled and a periodic stall
	always @(negedge clk) begin
		tick++;
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 120);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 4) == 0);
			default: m_axis_tready <= ((tick % 7) >= 3);
		endcase
	end

	// monitor: every accepted input goes to the predictor, every accepted result is checked
	always @(posedge clk) begin : monitor
		pot_item_t seen;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				seen.act = action_t'(s_axis_tuser);
				seen.channel = s_axis_tdata[4:0];
				seen.raw = s_axis_tdata[16:5];
				seen.now = s_axis_tdata[48:17];
				tracker.note_transfer(seen);
			end
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_result(pot_result_t'(m_axis_tdata[41:0]));
			// watchdog on a hung handshake
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [VAL_W-1:0] setting [4];
		int               pick;
		int               ch;
		int               v;
		action_t          act;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				// register settings per phase: extremes both ways, mid values,
				// random with junk above the 16-bit fields, then defaults again
				case (ph)
					1: setting = '{20'd0, 20'd0, 20'hFFFF, 20'hFFFF};
					2: setting = '{20'hFFFFF, 20'hFFFFF, 20'd0, 20'd0};
					3: setting = '{20'd30000, 20'd4000, 20'd300, 20'd40000};
					4: setting = '{20'($urandom_range(0, 80000)), 20'($urandom_range(0, 20000)),
						{4'($urandom), 16'($urandom_range(0, 3000))}, 20'($urandom)};
					default: setting = '{LOCKED_THR_RST, ACTIVE_THR_RST,
						20'(LOCK_TMO_RST), 20'(EMA_ALPHA_RST)};
				endcase
				// write order rotates with the phase; cfg_we stays high across the four writes
				for (int k = 0; k < 4; k++) begin
					cfg_we <= 1'b1;
					cfg_index <= cfg_reg_t'((k + ph) % 4);
					cfg_data <= setting[(k + ph) % 4];
					tracker.set_register(cfg_reg_t'((k + ph) % 4), setting[(k + ph) % 4]);
					@(negedge clk);
				end
				cfg_we <= 1'b0;
				@(negedge clk);
				// time wraps past zero during this phase
				if (ph == 3) clock_ms = 32'hFFFF_FC00;
			end else begin
				// directed: seed every channel first so that no unwritten entry is read
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					v = (c == 0) ? 0 : (c == 1 || c == 15) ? 4095 : $urandom_range(0, 4095);
					aim[c] = v;
					send_item(make_item(ACT_PRELOAD, c, v, $urandom));
				end
				// full-scale drop: reported while locked, then again while active
				send_item(make_item(ACT_SAMPLE, 1, 0, 32'd5000));
				send_item(make_item(ACT_SAMPLE, 1, 0, 32'd5100));
				send_item(make_item(ACT_SAMPLE, 0, 0, 32'd300));
				send_item(make_item(ACT_QUERY, 2, 4095, 32'd400));
				// lock-all with an invalid and a valid channel in the item
				send_item(make_item(ACT_LOCK_ALL, 31, 0, 32'd500));
				send_item(make_item(ACT_LOCK_ALL, 5, 4095, 32'd600));
				send_item(make_item(ACT_SAMPLE, 0, 4095, 32'hFFFF_FFFF));
				// invalid channels answer mid-scale and change nothing
				send_item(make_item(ACT_SAMPLE, 16, 4095, 32'd700));
				send_item(make_item(ACT_PRELOAD, 31, 4095, 32'd800));
				send_item(make_item(ACT_QUERY, 20, 0, 32'd900));
				send_item(make_item(ACT_PRELOAD, 0, 4095, 32'd0));
				aim[0] = 4095;
				aim[1] = 0;
				clock_ms = 32'd1000;
			end

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// time moves in small, medium and long steps, sometimes to anywhere
				pick = $urandom_range(0, 99);
				if (pick < 3) clock_ms = $urandom;
				else if (pick < 60) clock_ms += $urandom_range(0, 100);
				else if (pick < 90) clock_ms += $urandom_range(100, 1500);
				else clock_ms += $urandom_range(1500, 70000);

				pick = $urandom_range(0, 99);
				ch = $urandom_range(0, NUM_CHANNELS - 1);
				v = $urandom_range(0, 4095);
				if (pick < 68) begin
					// the knob mostly jitters around where it sits, sometimes jumps
					act = ACT_SAMPLE;
					if ($urandom_range(0, 3) == 0) begin
						pick = $urandom_range(0, 5);
						aim[ch] = (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(0, 4095);
					end
					v = aim[ch] + $urandom_range(0, 40) - 20;
					if (v < 0) v = 0;
					if (v > 4095) v = 4095;
				end else if (pick < 76) begin
					act = ACT_PRELOAD;
					aim[ch] = v;
				end else if (pick < 81) begin
					act = ACT_LOCK_ALL;
					ch = $urandom_range(0, 31);
				end else if (pick < 88) begin
					act = ACT_QUERY;
				end else begin
					act = action_t'($urandom_range(0, 3));
					ch = $urandom_range(NUM_CHANNELS, 31);
				end
				send_item(make_item(act, ch, v, clock_ms));
			end
			drain();
		end

		$display("covered %0d transfers over %0d register settings: %0d reported moves, %0d invalid",
			tracker.n_items, PHASES, tracker.n_moves, tracker.n_invalid);
		if (tracker.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", tracker.errors);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/psl_pkg.sv
design/psl_mac.sv
design/pot_smoother_with_lock.sv
design/psl_checker.sv
verif/pot_smoother_with_lock_test.sv
